>>> hdl/deqsum_pkg.sv
// Package for the double-ended queue with running sum.
// Holds field widths, operation and status codes, and the controller/datapath structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package deqsum_pkg;

    localparam int DEPTH_DEFAULT = 64;
    localparam int OPCODE_W      = 2;
    localparam int VALUE_W       = 32;
    localparam int STATUS_W      = 2;
    localparam int COUNT_W       = 7;
    localparam int SUM_W         = 38;

    typedef enum logic [OPCODE_W-1:0] {
        OP_PUSH_FRONT = 2'd0,
        OP_PUSH_BACK  = 2'd1,
        OP_POP_FRONT  = 2'd2,
        OP_POP_BACK   = 2'd3
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;    // capture the incoming transaction
        logic rd;      // issue the slot read for a pop
        logic commit;  // update queue state and load the result register
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_pop;
        logic empty;
        logic out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

>>> hdl/deqsum_if.sv
// Channel interfaces for the double-ended queue with running sum.
// Depends on deqsum_pkg for the payload widths.
`timescale 1ns / 1ps
`default_nettype none

interface deqsum_req_if;
    logic                                 valid;
    logic                                 ready;
    logic [deqsum_pkg::OPCODE_W-1:0]      opcode;
    logic signed [deqsum_pkg::VALUE_W-1:0] value;

    modport source (output valid, output opcode, output value, input ready);
    modport sink   (input valid, input opcode, input value, output ready);
endinterface

interface deqsum_rsp_if;
    logic                                valid;
    logic                                ready;
    logic [deqsum_pkg::STATUS_W-1:0]     status;
    logic [deqsum_pkg::COUNT_W-1:0]      element_count;
    logic signed [deqsum_pkg::SUM_W-1:0] total_sum;

    modport source (output valid, output status, output element_count, output total_sum,
                    input ready);
    modport sink   (input valid, input status, input element_count, input total_sum,
                    output ready);
endinterface

`default_nettype wire

>>> hdl/deqsum_ctrl.sv
// Controller state machine for the double-ended queue with running sum.
// Depends on deqsum_pkg for the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module deqsum_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire deqsum_pkg::dp_stat_t stat,
    output deqsum_pkg::dp_cmd_t       cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SUB
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        in_ready   = (state_reg == S_IDLE);
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                // A pop with data first issues the slot read.
                if (stat.is_pop && !stat.empty)
                begin
                    cmd.rd     = 1'b1;
                    state_next = S_SUB;
                end
                else if (stat.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_SUB:
            begin
                if (stat.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

>>> hdl/deqsum_dp.sv
// Datapath for the double-ended queue: slot memory, ring pointer, count, sum, result register.
// Depends on deqsum_pkg for widths, codes and the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module deqsum_dp #(
    parameter int DEPTH = deqsum_pkg::DEPTH_DEFAULT
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire deqsum_pkg::dp_cmd_t                    cmd,
    output deqsum_pkg::dp_stat_t                        stat,
    input  wire logic [deqsum_pkg::OPCODE_W-1:0]        in_opcode,
    input  wire logic signed [deqsum_pkg::VALUE_W-1:0]  in_value,
    output logic                                        out_valid,
    input  wire logic                                   out_ready,
    output logic [deqsum_pkg::STATUS_W-1:0]             out_status,
    output logic [deqsum_pkg::COUNT_W-1:0]              out_count,
    output logic signed [deqsum_pkg::SUM_W-1:0]         out_sum
);

    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int RING_W = CNT_W + 1;
    localparam int WIDE_W = CNT_W + deqsum_pkg::COUNT_W;

    localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(DEPTH);
    localparam logic [RING_W-1:0] RING_SPAN = RING_W'(DEPTH);

    logic [deqsum_pkg::VALUE_W-1:0] mem [DEPTH];

    deqsum_pkg::opcode_t              op_reg;
    logic [deqsum_pkg::VALUE_W-1:0]   val_reg;
    logic [deqsum_pkg::VALUE_W-1:0]   rdata_reg;
    logic [IDX_W-1:0]                 head_reg;
    logic [IDX_W-1:0]                 head_next;
    logic [CNT_W-1:0]                 occ_reg;
    logic [CNT_W-1:0]                 occ_next;
    logic [deqsum_pkg::SUM_W-1:0]     sum_reg;
    logic [deqsum_pkg::SUM_W-1:0]     sum_next;
    deqsum_pkg::status_t              status_next;
    logic                             out_valid_reg;
    logic [deqsum_pkg::STATUS_W-1:0]  status_reg;
    logic [deqsum_pkg::COUNT_W-1:0]   count_reg;
    logic [deqsum_pkg::SUM_W-1:0]     osum_reg;

    logic [IDX_W-1:0]                 head_prev;
    logic [IDX_W-1:0]                 head_inc;
    logic [RING_W-1:0]                back_wr_raw;
    logic [RING_W-1:0]                back_rd_raw;
    logic [IDX_W-1:0]                 back_wr_idx;
    logic [IDX_W-1:0]                 back_rd_idx;
    logic [IDX_W-1:0]                 rd_addr;
    logic [IDX_W-1:0]                 wr_addr;
    logic                             wr_en;
    logic                             empty;
    logic                             full;
    logic [deqsum_pkg::SUM_W-1:0]     val_ext;
    logic [deqsum_pkg::SUM_W-1:0]     rdata_ext;
    logic [WIDE_W-1:0]                occ_wide;

    assign empty = (occ_reg == '0);
    assign full  = (occ_reg == FULL_CNT);

    assign head_prev = (head_reg == '0) ? LAST_IDX : head_reg - 1'b1;
    assign head_inc  = (head_reg == LAST_IDX) ? '0 : head_reg + 1'b1;

    // Ring offsets stay below twice the depth, so one compare and subtract wraps them.
    assign back_wr_raw = RING_W'(head_reg) + RING_W'(occ_reg);
    assign back_rd_raw = RING_W'(head_reg) + RING_W'(occ_reg) - 1'b1;
    always_comb
    begin
        logic [RING_W-1:0] wr_wrap;
        logic [RING_W-1:0] rd_wrap;
        wr_wrap     = (back_wr_raw >= RING_SPAN) ? back_wr_raw - RING_SPAN : back_wr_raw;
        rd_wrap     = (back_rd_raw >= RING_SPAN) ? back_rd_raw - RING_SPAN : back_rd_raw;
        back_wr_idx = wr_wrap[IDX_W-1:0];
        back_rd_idx = rd_wrap[IDX_W-1:0];
    end

    assign val_ext   = {{(deqsum_pkg::SUM_W - deqsum_pkg::VALUE_W){val_reg[deqsum_pkg::VALUE_W-1]}},
                        val_reg};
    assign rdata_ext = {{(deqsum_pkg::SUM_W - deqsum_pkg::VALUE_W){rdata_reg[deqsum_pkg::VALUE_W-1]}},
                        rdata_reg};

    assign rd_addr = (op_reg == deqsum_pkg::OP_POP_FRONT) ? head_reg : back_rd_idx;

    always_comb
    begin
        head_next   = head_reg;
        occ_next    = occ_reg;
        sum_next    = sum_reg;
        status_next = deqsum_pkg::ST_OK;
        wr_en       = 1'b0;
        wr_addr     = back_wr_idx;
        unique case (op_reg)
            deqsum_pkg::OP_PUSH_FRONT:
            begin
                if (full)
                begin
                    status_next = deqsum_pkg::ST_FULL;
                end
                else
                begin
                    head_next = head_prev;
                    wr_addr   = head_prev;
                    wr_en     = 1'b1;
                    occ_next  = occ_reg + 1'b1;
                    sum_next  = sum_reg + val_ext;
                end
            end
            deqsum_pkg::OP_PUSH_BACK:
            begin
                if (full)
                begin
                    status_next = deqsum_pkg::ST_FULL;
                end
                else
                begin
                    wr_en    = 1'b1;
                    occ_next = occ_reg + 1'b1;
                    sum_next = sum_reg + val_ext;
                end
            end
            deqsum_pkg::OP_POP_FRONT:
            begin
                if (empty)
                begin
                    status_next = deqsum_pkg::ST_EMPTY;
                end
                else
                begin
                    head_next = head_inc;
                    occ_next  = occ_reg - 1'b1;
                    sum_next  = sum_reg - rdata_ext;
                end
            end
            deqsum_pkg::OP_POP_BACK:
            begin
                if (empty)
                begin
                    status_next = deqsum_pkg::ST_EMPTY;
                end
                else
                begin
                    occ_next = occ_reg - 1'b1;
                    sum_next = sum_reg - rdata_ext;
                end
            end
            default:
            begin
                status_next = deqsum_pkg::ST_OK;
            end
        endcase
    end

    // The reported count is taken modulo its field width.
    assign occ_wide = WIDE_W'(occ_next);

    always_ff @(posedge clk)
    begin
        if (cmd.commit && wr_en)
        begin
            mem[wr_addr] <= val_reg;
        end
        if (cmd.rd)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= deqsum_pkg::opcode_t'(in_opcode);
            val_reg <= in_value;
        end
        if (cmd.commit)
        begin
            status_reg <= status_next;
            count_reg  <= occ_wide[deqsum_pkg::COUNT_W-1:0];
            osum_reg   <= sum_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            occ_reg       <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.commit)
            begin
                head_reg      <= head_next;
                occ_reg       <= occ_next;
                sum_reg       <= sum_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.is_pop   = (op_reg == deqsum_pkg::OP_POP_FRONT) ||
                           (op_reg == deqsum_pkg::OP_POP_BACK);
    assign stat.empty    = empty;
    assign stat.out_free = !out_valid_reg || out_ready;

    assign out_valid  = out_valid_reg;
    assign out_status = status_reg;
    assign out_count  = count_reg;
    assign out_sum    = osum_reg;

endmodule

`default_nettype wire

>>> hdl/double_ended_queue_with_sum.sv
// Double-ended queue of signed 32-bit values with an exact running sum (top level).
// Depends on deqsum_pkg, deqsum_if, deqsum_ctrl and deqsum_dp.
//
// Usage: the req channel carries one operation per transaction: opcode (push front,
// push back, pop front, pop back) and value (used by pushes only). For every request
// transaction the rsp channel returns exactly one transaction with status (ok, pop on
// an empty queue, push on a full queue), element_count and total_sum after the
// operation, in request order. Popped values are discarded.
// Sequence: a push or a rejected operation commits from the execute state once the output
// register is free; a pop that removes a value first issues a slot read, because the slot
// memory has a single port with registered read data.
// The controller takes one request at a time: a new request is not accepted until the
// previous one has committed its response.
// The response sits in an output register, so the next request is accepted while a
// response still waits; if the receiver stalls, the following operation is captured,
// a pop also reads its slot, and it then holds until the output register is free.
// Reset: an asynchronous low reset empties the queue (count 0, sum 0) and drops any
// pending response. The slot memory is not cleared; a slot is only read after a push
// wrote it.
`timescale 1ns / 1ps
`default_nettype none

module double_ended_queue_with_sum #(
    parameter int DEPTH = deqsum_pkg::DEPTH_DEFAULT
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    deqsum_req_if.sink   req,
    deqsum_rsp_if.source rsp
);

    deqsum_pkg::dp_cmd_t  cmd;
    deqsum_pkg::dp_stat_t stat;
    logic                 req_ready;

    // The controller sequences each transaction: capture, optional slot read, commit.
    deqsum_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // The datapath owns the ring buffer, the pointers, the sum and the response register.
    deqsum_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .in_opcode  (req.opcode),
        .in_value   (req.value),
        .out_valid  (rsp.valid),
        .out_ready  (rsp.ready),
        .out_status (rsp.status),
        .out_count  (rsp.element_count),
        .out_sum    (rsp.total_sum)
    );

    assign req.ready = req_ready;

endmodule

`default_nettype wire

>>> hdl/deqsum_chk.sv
// Port-level checker for the double-ended queue with running sum, bound to the top level.
// Depends on deqsum_pkg for the status codes.
`timescale 1ns / 1ps
`default_nettype none

module deqsum_chk #(
    parameter int DEPTH = deqsum_pkg::DEPTH_DEFAULT
) (
    input wire logic                                clk,
    input wire logic                                rst_n,
    input wire logic                                rsp_valid,
    input wire logic                                rsp_ready,
    input wire logic [deqsum_pkg::STATUS_W-1:0]     rsp_status,
    input wire logic [deqsum_pkg::COUNT_W-1:0]      rsp_count,
    input wire logic signed [deqsum_pkg::SUM_W-1:0] rsp_sum
);

    localparam logic [deqsum_pkg::COUNT_W-1:0] FULL_COUNT = deqsum_pkg::COUNT_W'(DEPTH);
    localparam bit COUNT_FITS = (DEPTH < (1 << deqsum_pkg::COUNT_W));

    // A stalled response stays offered.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response dropped while stalled");

    // A pop on an empty queue reports an empty, zero-sum queue.
    a_empty_state: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status == deqsum_pkg::ST_EMPTY |-> rsp_count == '0 && rsp_sum == '0)
        else $error("empty status with nonzero count or sum");

    // A rejected push reports a queue at capacity.
    a_full_state: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status == deqsum_pkg::ST_FULL |-> rsp_count == FULL_COUNT)
        else $error("full status below capacity");

    // The count never exceeds capacity, and an empty queue sums to zero.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && COUNT_FITS |-> rsp_count <= FULL_COUNT &&
                                    (rsp_count != '0 || rsp_sum == '0))
        else $error("count above capacity or nonzero sum of empty queue");

endmodule

bind double_ended_queue_with_sum deqsum_chk #(
    .DEPTH (DEPTH)
) u_deqsum_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .rsp_status (rsp.status),
    .rsp_count  (rsp.element_count),
    .rsp_sum    (rsp.total_sum)
);

`default_nettype wire

>>> bench/tb_double_ended_queue_with_sum.sv
// Self-checking testbench for the double-ended queue with running sum.
// Depends on deqsum_pkg, deqsum_if and the double_ended_queue_with_sum RTL.
`timescale 1ns / 1ps

module tb_double_ended_queue_with_sum;

    localparam int QUEUE_DEPTH     = deqsum_pkg::DEPTH_DEFAULT;
    localparam int INDEX_W         = $clog2(QUEUE_DEPTH);
    localparam int HOLD_OFF_CYCLES = 200;
    localparam int VAL_W           = deqsum_pkg::VALUE_W;
    localparam int EXT_W           = deqsum_pkg::SUM_W - deqsum_pkg::VALUE_W;

    // One expected response: the status and the queue state after the operation.
    typedef struct packed {
        deqsum_pkg::status_t                 status;
        logic [deqsum_pkg::COUNT_W-1:0]      count;
        logic signed [deqsum_pkg::SUM_W-1:0] sum;
    } deque_result_t;

    // The scoreboard keeps its own copy of the ring buffer, the front index, the
    // occupancy and the running sum. Every accepted request transaction is applied
    // to that copy and the resulting status, count and sum are queued; every accepted
    // response transaction is checked against the oldest queued entry.
    class deque_scoreboard;
        logic signed [VAL_W-1:0]             slots [QUEUE_DEPTH];
        logic [INDEX_W-1:0]                  front_index;
        int                                  occupancy;
        logic signed [deqsum_pkg::SUM_W-1:0] running_sum;
        deque_result_t                       expected_results [$];
        int                                  error_count;

        function new();
            front_index = '0;
            occupancy   = 0;
            running_sum = '0;
            error_count = 0;
        endfunction

        function void note_request(deqsum_pkg::opcode_t op, logic signed [VAL_W-1:0] val);
            logic [INDEX_W-1:0] slot_index;
            deque_result_t      result;
            result.status = deqsum_pkg::ST_OK;
            if (op == deqsum_pkg::OP_PUSH_FRONT || op == deqsum_pkg::OP_PUSH_BACK) begin
                if (occupancy >= QUEUE_DEPTH) begin
                    result.status = deqsum_pkg::ST_FULL;
                end
                else begin
                    if (op == deqsum_pkg::OP_PUSH_FRONT) begin
                        front_index = front_index - 1'b1;
                        slot_index  = front_index;
                    end
                    else begin
                        slot_index = front_index + INDEX_W'(occupancy);
                    end
                    slots[slot_index] = val;
                    occupancy++;
                    running_sum = running_sum + {{EXT_W{val[VAL_W-1]}}, val};
                end
            end
            else begin
                if (occupancy == 0) begin
                    result.status = deqsum_pkg::ST_EMPTY;
                end
                else begin
                    if (op == deqsum_pkg::OP_POP_FRONT) begin
                        slot_index  = front_index;
                        front_index = front_index + 1'b1;
                    end
                    else begin
                        slot_index = front_index + INDEX_W'(occupancy - 1);
                    end
                    running_sum = running_sum -
                        {{EXT_W{slots[slot_index][VAL_W-1]}}, slots[slot_index]};
                    occupancy--;
                end
            end
            result.count = deqsum_pkg::COUNT_W'(occupancy);
            result.sum   = running_sum;
            expected_results.push_back(result);
        endfunction

        function void report_mismatch(string field, longint expected, longint actual);
            error_count++;
            $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                     $time, field, expected, actual);
        endfunction

        function void check_response(deqsum_pkg::status_t st,
                                     logic [deqsum_pkg::COUNT_W-1:0] count,
                                     logic signed [deqsum_pkg::SUM_W-1:0] total);
            deque_result_t expected;
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected response, status", -1, st);
                return;
            end
            expected = expected_results.pop_front();
            if (st !== expected.status) begin
                report_mismatch("status", expected.status, st);
            end
            if (count !== expected.count) begin
                report_mismatch("element_count", expected.count, count);
            end
            if (total !== expected.sum) begin
                report_mismatch("total_sum", expected.sum, total);
            end
        endfunction

        function int pending();
            return expected_results.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;

    deqsum_req_if req ();
    deqsum_rsp_if rsp ();

    double_ended_queue_with_sum uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    deque_scoreboard sb;

    // Idle percentages for the two sides. The main sequence changes them between
    // the phases of the run.
    int  send_idle_pct;
    int  recv_idle_pct;

    // The long receiver hold-off runs in its own process once it is requested.
    logic hold_off_request;
    logic hold_off;

    always #5 clk = ~clk;

    // The receiver decides at every falling edge whether it takes a response in the
    // next cycle. During the hold-off it takes nothing, so the output register stays
    // occupied and the block has to stall its request channel.
    always @(negedge clk) begin
        rsp.ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
    end

    // Responses are checked at the rising edge where the handshake completes.
    always @(posedge clk) begin
        if (rst_n && rsp.valid && rsp.ready) begin
            sb.check_response(deqsum_pkg::status_t'(rsp.status), rsp.element_count,
                              rsp.total_sum);
        end
    end

    // The hold-off length is counted here in clock cycles; the flag changes at rising
    // edges so that the ready process at the falling edge always sees a settled value.
    initial begin
        hold_off = 1'b0;
        wait (hold_off_request);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    // Offers one request transaction, first idling for a random number of cycles, and
    // returns at the falling edge after it was accepted. The scoreboard learns of the
    // request at the accepting edge, so the expected queue is always in request order.
    // Valid is only ever driven once per falling edge.
    task automatic send_request(deqsum_pkg::opcode_t op, logic signed [VAL_W-1:0] val);
        while ($urandom_range(99) < send_idle_pct) begin
            req.valid <= 1'b0;
            @(negedge clk);
        end
        req.valid  <= 1'b1;
        req.opcode <= op;
        req.value  <= val;
        do
            @(posedge clk);
        while (!req.ready);
        sb.note_request(op, val);
        @(negedge clk);
    endtask

    // Values favor the extremes, so that the running sum reaches its far ends when
    // the queue fills, while plain random words still set every bit both ways.
    function automatic logic signed [VAL_W-1:0] random_value();
        case ($urandom_range(9))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return '0;
            3:       return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    // A push with the given probability, otherwise a pop; the end is chosen at random.
    function automatic deqsum_pkg::opcode_t random_operation(int push_pct);
        if ($urandom_range(99) < push_pct) begin
            return $urandom_range(1) ? deqsum_pkg::OP_PUSH_BACK : deqsum_pkg::OP_PUSH_FRONT;
        end
        return $urandom_range(1) ? deqsum_pkg::OP_POP_BACK : deqsum_pkg::OP_POP_FRONT;
    endfunction

    task automatic run_operations(int count, int push_pct);
        for (int i = 0; i < count; i++) begin
            send_request(random_operation(push_pct), random_value());
        end
    endtask

    // Alternates push-heavy and pop-heavy segments so that the queue keeps swinging
    // between empty and full, and both the rejected push and the rejected pop happen
    // many times with the ring indexes at many positions.
    task automatic run_swings(int count);
        int issued;
        int seg_len;
        int push_pct;
        issued = 0;
        push_pct = 85;
        while (issued < count) begin
            seg_len = $urandom_range(120, 40);
            if (seg_len > count - issued) begin
                seg_len = count - issued;
            end
            run_operations(seg_len, push_pct);
            issued += seg_len;
            case ($urandom_range(2))
                0:       push_pct = 85;
                1:       push_pct = 15;
                default: push_pct = 50;
            endcase
        end
    endtask

    initial begin
        clk              = 1'b0;
        rst_n            = 1'b0;
        req.valid        = 1'b0;
        req.opcode       = deqsum_pkg::OP_PUSH_FRONT;
        req.value        = '0;
        rsp.ready        = 1'b0;
        hold_off_request = 1'b0;
        send_idle_pct    = 18;
        recv_idle_pct    = 60;
        sb               = new();

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed part: pops on an empty queue at both ends, pushes of the extreme
        // values at both ends, pops from both ends down to empty, and one more pop
        // on the empty queue after it has been used.
        send_request(deqsum_pkg::OP_POP_FRONT,  random_value());
        send_request(deqsum_pkg::OP_POP_BACK,   random_value());
        send_request(deqsum_pkg::OP_PUSH_BACK,  32'sh7FFF_FFFF);
        send_request(deqsum_pkg::OP_PUSH_FRONT, 32'sh8000_0000);
        send_request(deqsum_pkg::OP_PUSH_BACK,  -32'sd1);
        send_request(deqsum_pkg::OP_PUSH_FRONT, 32'sd0);
        send_request(deqsum_pkg::OP_PUSH_BACK,  32'sd1);
        send_request(deqsum_pkg::OP_POP_BACK,   32'sd0);
        send_request(deqsum_pkg::OP_POP_FRONT,  32'sd0);
        send_request(deqsum_pkg::OP_PUSH_FRONT, 32'sh7FFF_FFFF);
        send_request(deqsum_pkg::OP_PUSH_BACK,  32'sh8000_0000);
        send_request(deqsum_pkg::OP_POP_FRONT,  -32'sd1);
        send_request(deqsum_pkg::OP_POP_BACK,   -32'sd1);
        send_request(deqsum_pkg::OP_POP_FRONT,  32'sh7FFF_FFFF);
        send_request(deqsum_pkg::OP_POP_BACK,   32'sh8000_0000);
        send_request(deqsum_pkg::OP_POP_BACK,   32'sd5);
        send_request(deqsum_pkg::OP_POP_FRONT,  32'sd5);

        // Random part, first with a slow receiver, then with a slow sender, then
        // with neither side idling.
        run_swings(260);
        send_idle_pct = 60;
        recv_idle_pct = 18;
        run_swings(260);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_swings(260);

        // Back pressure: the receiver stops for a long stretch while the sender keeps
        // pushing, so the block fills its output register and stalls the request
        // channel. The pushes continue past capacity to hit the full case, then pops
        // drain the queue past empty.
        hold_off_request = 1'b1;
        run_operations(90, 100);
        run_operations(90, 0);
        req.valid <= 1'b0;

        // Wait for every expected response, then give the block a few more cycles
        // in case it sends something that nobody asked for.
        while (sb.pending() != 0) begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);

        if (sb.error_count == 0) begin
            $display("[double_ended_queue_with_sum] OK");
        end
        else begin
            $display("[double_ended_queue_with_sum] ERROR");
        end
        $finish;
    end

    // Watchdog: far longer than the slowest correct run needs.
    initial begin
        #5_000_000;
        $display("[double_ended_queue_with_sum] ERROR");
        $finish;
    end

endmodule
